// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the summarizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Assertion sampled on clk, held off while rst is high
`define MSC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("msm_cnr assertion failed");
// Assertion sampled on clk at every edge, reset included
`define MSC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("msm_cnr assertion failed");
`else
`define MSC_ASSERT(lbl, clk, rst, prop)
`define MSC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== design/msm_cnr_pkg.sv =====
// ----------------------------------------------------------------------------
// msm_cnr_pkg
// Shared types, constants and helpers of the MSM CNR summarizer.
// ----------------------------------------------------------------------------
`default_nettype none
package msm_cnr_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned SumW        = 21;
  localparam int unsigned OutW        = 56;

  localparam logic [7:0]  Preamble  = 8'hD3;
  localparam logic [11:0] TypeMin   = 12'd1071;
  localparam logic [11:0] TypeMax   = 12'd1127;
  localparam logic [11:0] TypeBase  = 12'd1070;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_FRAME = 3'd1;
  localparam logic [2:0] ST_BAD_CRC   = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_BAD_MSM   = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic div_init;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic take_bits;
    logic adv_pend;
    logic last;
  } dp_sts_t;

  // Advance CRC-24Q by one byte, MSB first
  function automatic logic [23:0] crc_byte(input logic [23:0] c, input logic [7:0] b);
    logic [23:0] r;
    r = c ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      r = {r[22:0], 1'b0} ^ (r[23] ? 24'h864CFB : 24'h000000);
    end
    return r;
  endfunction

  function automatic logic type_in_range(input logic [11:0] t);
    return (t >= TypeMin) && (t <= TypeMax);
  endfunction

  // Returns {is_msm7, is_msm4}; both low when out of range
  function automatic logic [1:0] type_class(input logic [11:0] t);
    logic [11:0] d;
    logic [5:0]  v;
    d = t - TypeBase;
    v = d[5:0];
    for (int i = 0; i < 5; i++) begin
      if (v >= 6'd10) v = v - 6'd10;
    end
    return {type_in_range(t) && (v == 6'd7), type_in_range(t) && (v == 6'd4)};
  endfunction

endpackage
`default_nettype wire

// ===== design/msm_mean_cnr_summarizer.sv =====
// ----------------------------------------------------------------------------
// msm_mean_cnr_summarizer
// Parses one MSM4/MSM7 correction frame per run of bytes and reports its
// status, header and mean CNR.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_*     | in  | tdata[7:0] frame byte, tlast last byte of frame
//  m_*     | out | tdata status, msg_type, station_id, sat_count, sig_count,
//          |     | mean_cnr
//
// Each byte is loaded and then, if it is payload, walked bit by bit; the
// walker also takes a step into each field group it enters, empty or not
// (at most 6 in a byte). After the final byte come 21 serial divider steps
// and one capture; the next cycle offers the result from its own register.
// Capture waits while the previous result is still held by m_tready low.
// rst synchronously clears the controller and the frame state.
// ----------------------------------------------------------------------------
`default_nettype none
module msm_mean_cnr_summarizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[2:0], msg_type[14:3], station_id[26:15], sat_count[33:27],
  // sig_count[39:34], mean_cnr[55:40]
  output logic [55:0]      m_tdata
);

  msm_cnr_pkg::dp_cmd_t cmd;
  msm_cnr_pkg::dp_sts_t sts;

  msm_cnr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  msm_cnr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .result    (m_tdata)
  );

endmodule
`default_nettype wire

// ===== design/msm_cnr_dp.sv =====
// ----------------------------------------------------------------------------
// msm_cnr_dp
// Datapath: byte checks, CRC, bit-serial field walker, CNR sum and divider.
// ----------------------------------------------------------------------------
`default_nettype none
module msm_cnr_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire msm_cnr_pkg::dp_cmd_t        cmd,
  output msm_cnr_pkg::dp_sts_t             sts,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        last_byte,
  output logic [msm_cnr_pkg::OutW-1:0]     result
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_TYPE, PH_STATION, PH_HDRSKIP, PH_SATMASK, PH_SIGMASK,
    PH_CELLMASK, PH_SATDATA, PH_CELLSKIP, PH_CNR, PH_TAIL, PH_DONE, PH_STOP
  } phase_t;

  logic [10:0] byte_index;
  logic [9:0]  payload_length;
  logic [23:0] crc_register, received_crc;
  phase_t      phase;
  logic [17:0] bits_to_go;
  logic [11:0] field_shift, type_seen, station_seen;
  logic [6:0]  sats_found;
  logic [5:0]  sigs_found;
  logic [11:0] cells_found, cells_read;
  logic [msm_cnr_pkg::SumW-1:0] cnr_sum;
  logic        error_code, msm7, adv_pend, take_bits, last_q;
  logic [7:0]  byte_sr;
  logic [msm_cnr_pkg::SumW-1:0] quot;
  logic [11:0] rem;
  logic [2:0]  o_status;
  logic [11:0] o_type, o_station;
  logic [6:0]  o_sats;
  logic [5:0]  o_sigs;
  logic [15:0] o_mean;

  // Byte-level decode
  logic [9:0]  pl_new;
  logic [10:0] idx_next, crc_end, frame_end;
  logic        in_crc, in_rcrc, take_new;

  always_comb begin
    pl_new = payload_length;
    if (byte_index == 11'd1) pl_new = {data_byte[1:0], 8'h00};
    else if (byte_index == 11'd2) pl_new = {payload_length[9:8], data_byte};
    crc_end   = {1'b0, pl_new} + 11'd3;
    frame_end = {1'b0, pl_new} + 11'd6;
    in_crc    = byte_index < crc_end;
    in_rcrc   = !in_crc && (byte_index < frame_end);
    take_new  = in_crc && (byte_index >= 11'd3);
    idx_next  = (byte_index == 11'h7FF) ? byte_index : byte_index + 11'd1;
  end

  // Bit step decode
  logic        bit_in, bit_live;
  logic [11:0] fs_shift;
  logic [17:0] btg_dec;
  logic [1:0]  cls_new;
  logic [12:0] cnr7;
  logic [9:0]  cnr_add;
  logic [11:0] cr_inc;

  always_comb begin
    bit_in   = byte_sr[7];
    bit_live = (phase >= PH_TYPE) && (phase < PH_DONE) && (bits_to_go != 18'd0);
    fs_shift = {field_shift[10:0], bit_in};
    btg_dec  = bits_to_go - 18'd1;
    cls_new  = msm_cnr_pkg::type_class(fs_shift);
    cnr7     = {3'b000, fs_shift[9:0]} * 13'd5;
    cnr_add  = msm7 ? cnr7[12:3] : ({4'b0000, fs_shift[5:0]} * 10'd10);
    cr_inc   = cells_read + 12'd1;
  end

  // Length of the next phase for the advance step
  phase_t      p_inc;
  logic [17:0] len_inc;

  always_comb begin
    p_inc = phase_t'(phase + 4'd1);
    case (p_inc)
      PH_TYPE, PH_STATION: len_inc = 18'd12;
      PH_HDRSKIP:  len_inc = 18'd49;
      PH_SATMASK:  len_inc = 18'd64;
      PH_SIGMASK:  len_inc = 18'd32;
      PH_CELLMASK: len_inc = {5'd0, {6'd0, sats_found} * {7'd0, sigs_found}};
      PH_SATDATA:  len_inc = {5'd0, {6'd0, sats_found} * (msm7 ? 13'd36 : 13'd18)};
      PH_CELLSKIP: len_inc = {6'd0, cells_found} * (msm7 ? 18'd55 : 18'd42);
      PH_CNR:      len_inc = (cells_found == 12'd0) ? 18'd0 : (msm7 ? 18'd10 : 18'd6);
      PH_TAIL:     len_inc = msm7 ? {6'd0, cells_found} * 18'd15 : 18'd0;
      default:     len_inc = 18'd0;
    endcase
  end

  // Frame state, cleared on reset and after each result
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      byte_index <= '0; payload_length <= '0; crc_register <= '0;
      received_crc <= '0; phase <= PH_IDLE; bits_to_go <= '0;
      field_shift <= '0; type_seen <= '0; station_seen <= '0;
      sats_found <= '0; sigs_found <= '0; cells_found <= '0;
      cells_read <= '0; cnr_sum <= '0; error_code <= 1'b0; msm7 <= 1'b0;
      adv_pend <= 1'b0; take_bits <= 1'b0; last_q <= 1'b0;
    end else if (cmd.load) begin
      byte_index     <= idx_next;
      payload_length <= pl_new;
      take_bits      <= take_new;
      last_q         <= last_byte;
      if (in_crc) crc_register <= msm_cnr_pkg::crc_byte(crc_register, data_byte);
      if (in_rcrc) received_crc <= {received_crc[15:0], data_byte};
      if (byte_index == 11'd0) begin
        error_code  <= data_byte != msm_cnr_pkg::Preamble;
        phase       <= PH_TYPE;
        bits_to_go  <= 18'd12;
        field_shift <= '0;
      end
    end else if (cmd.step) begin
      if (adv_pend) begin
        // Skip over empty phases one per cycle
        phase      <= p_inc;
        bits_to_go <= len_inc;
        if (len_inc != 18'd0 || p_inc == PH_DONE) adv_pend <= 1'b0;
      end else if (bit_live) begin
        field_shift <= fs_shift;
        bits_to_go  <= btg_dec;
        if (phase == PH_SATMASK) sats_found <= sats_found + {6'd0, bit_in};
        if (phase == PH_SIGMASK) sigs_found <= sigs_found + {5'd0, bit_in};
        if (phase == PH_CELLMASK) cells_found <= cells_found + {11'd0, bit_in};
        if (btg_dec == 18'd0) begin
          field_shift <= '0;
          case (phase)
            PH_TYPE: begin
              type_seen <= fs_shift;
              msm7      <= cls_new[1];
              if (cls_new == 2'b00) phase <= PH_STOP;
              else adv_pend <= 1'b1;
            end
            PH_STATION: begin
              station_seen <= fs_shift;
              adv_pend     <= 1'b1;
            end
            PH_CNR: begin
              cnr_sum    <= cnr_sum + {11'd0, cnr_add};
              cells_read <= cr_inc;
              if (cr_inc < cells_found) bits_to_go <= msm7 ? 18'd10 : 18'd6;
              else adv_pend <= 1'b1;
            end
            default: adv_pend <= 1'b1;
          endcase
        end
      end
    end
  end

  // Byte shifter for the bit walker
  always_ff @(posedge clk) begin
    if (cmd.load) byte_sr <= data_byte;
    else if (cmd.step && !adv_pend) byte_sr <= {byte_sr[6:0], 1'b0};
  end

  // Restoring divide, one quotient bit a cycle
  logic [12:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem, quot[msm_cnr_pkg::SumW-1]};
    fits  = trial >= {1'b0, cells_found};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quot <= cnr_sum;
      rem  <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[msm_cnr_pkg::SumW-2:0], fits};
      rem  <= fits ? 12'(trial - {1'b0, cells_found}) : trial[11:0];
    end
  end

  // Final status, first fault wins
  logic [2:0]  status_c;
  logic [1:0]  cls_fin;

  always_comb begin
    cls_fin = msm_cnr_pkg::type_class(type_seen);
    if (error_code || byte_index != {1'b0, payload_length} + 11'd6)
      status_c = msm_cnr_pkg::ST_BAD_FRAME;
    else if (crc_register != received_crc)
      status_c = msm_cnr_pkg::ST_BAD_CRC;
    else if (phase <= PH_TYPE || !msm_cnr_pkg::type_in_range(type_seen))
      status_c = msm_cnr_pkg::ST_BAD_TYPE;
    else if (cls_fin == 2'b00)
      status_c = msm_cnr_pkg::ST_BAD_MSM;
    else if (phase != PH_DONE)
      status_c = msm_cnr_pkg::ST_TRUNC;
    else
      status_c = msm_cnr_pkg::ST_OK;
  end

  // Capture the result
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_status <= status_c;
      if (status_c == msm_cnr_pkg::ST_OK) begin
        o_type    <= type_seen;
        o_station <= station_seen;
        o_sats    <= sats_found;
        o_sigs    <= sigs_found;
        o_mean    <= (cells_found == 12'd0) ? 16'hFFFF : quot[15:0];
      end else begin
        o_type <= '0; o_station <= '0; o_sats <= '0; o_sigs <= '0; o_mean <= '0;
      end
    end
  end

  assign result = {o_mean, o_sigs, o_sats, o_station, o_type, o_status};
  assign sts    = '{take_bits: take_bits, adv_pend: adv_pend, last: last_q};

endmodule
`default_nettype wire

// ===== design/msm_cnr_ctrl.sv =====
// ----------------------------------------------------------------------------
// msm_cnr_ctrl
// Controller: sequences byte load, bit walk, divide and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module msm_cnr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output msm_cnr_pkg::dp_cmd_t      cmd,
  input  wire msm_cnr_pkg::dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_BITS = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t      state, state_next;
  logic [3:0]  bit_cnt, bit_cnt_next;
  logic [4:0]  div_cnt, div_cnt_next;
  logic        out_valid, out_valid_next;
  logic        bits_left;

  // Next state and commands
  always_comb begin
    state_next     = state;
    bit_cnt_next   = bit_cnt;
    div_cnt_next   = div_cnt;
    out_valid_next = out_valid && !m_tready;
    cmd            = '0;
    s_tready       = 1'b0;
    m_tvalid       = out_valid;
    bits_left      = sts.take_bits && (bit_cnt != 4'(msm_cnr_pkg::BitsPerByte));
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load     = 1'b1;
          bit_cnt_next = '0;
          state_next   = S_BITS;
        end
      end
      S_BITS: begin
        if (sts.adv_pend || bits_left) begin
          cmd.step = 1'b1;
          if (!sts.adv_pend) bit_cnt_next = bit_cnt + 4'd1;
        end else if (sts.last) begin
          cmd.div_init = 1'b1;
          div_cnt_next = '0;
          state_next   = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 5'd1;
        if (div_cnt == 5'(msm_cnr_pkg::SumW - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        // Capture once the output register is free or being emptied
        if (!out_valid || m_tready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bit_cnt   <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      bit_cnt   <= bit_cnt_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `MSC_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  `MSC_ASSERT(a_finish_shows, clk, rst, cmd.finish |=> m_tvalid)
  `MSC_ASSERT(a_finish_free, clk, rst, cmd.finish |-> (!m_tvalid || m_tready))
  `MSC_ASSERT(a_bit_cnt_bound, clk, rst, (state == S_BITS) |-> (bit_cnt <= 4'd8))
  `MSC_ASSERT(a_div_cnt_bound, clk, rst, (state == S_DIV) |-> (div_cnt <= 5'd20))

endmodule
`default_nettype wire

// ===== tb/sv/msm_mean_cnr_summarizer_tb.sv =====
// ----------------------------------------------------------------------------
// msm_mean_cnr_summarizer_tb
// Self-checking bench for the MSM CNR summarizer. Builds correction frames bit
// by bit (valid MSM4/MSM7 bodies, framing faults, bad CRCs, odd types,
// truncated bodies, noise), streams them in byte transfers with random gaps,
// predicts each frame summary in a byte-level model and compares every field
// of every result transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module msm_mean_cnr_summarizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  // Summary fields, msb first so the layout matches m_tdata
  typedef struct packed {
    logic [15:0] mean_cnr;
    logic [5:0]  sig_count;
    logic [6:0]  sat_count;
    logic [11:0] station_id;
    logic [11:0] msg_type;
    logic [2:0]  status;
  } summary_t;

  // Body walker phases
  localparam int unsigned W_IDLE = 0, W_TYPE = 1, W_STATION = 2, W_HDRSKIP = 3;
  localparam int unsigned W_SATMASK = 4, W_SIGMASK = 5, W_CELLMASK = 6, W_SATDATA = 7;
  localparam int unsigned W_CELLSKIP = 8, W_CNR = 9, W_TAIL = 10, W_DONE = 11;
  localparam int unsigned W_STOP = 12;

  // Frame faults
  localparam int F_NONE = 0, F_PREAMBLE = 1, F_LEN_SHORT = 2, F_LEN_LONG = 3;
  localparam int F_CRC = 4;

  // CNR value choice per cell
  localparam int CNR_MIN = 0, CNR_MAX = 1, CNR_RAND = 2;

  localparam int unsigned CycleLimit = 4000000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  summary_t    summary_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned results_seen;
  int unsigned bytes_sent;
  int unsigned hold_req;
  bit          no_idle;

  // Prediction state
  int unsigned p_idx, p_len, p_crc, p_rcrc, p_phase, p_shift, p_togo;
  int unsigned p_type, p_station, p_sats, p_sigs, p_cells, p_read, p_sum, p_err;

  // Frame body under construction
  bit body_bits[$];

  msm_mean_cnr_summarizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------- prediction
  function automatic bit walker_m7();
    return (p_type % 10) == 7;
  endfunction

  function automatic int unsigned group_bits(int unsigned ph);
    bit m7;
    m7 = walker_m7();
    case (ph)
      W_TYPE:     return 12;
      W_STATION:  return 12;
      W_HDRSKIP:  return 49;
      W_SATMASK:  return 64;
      W_SIGMASK:  return 32;
      W_CELLMASK: return p_sats * p_sigs;
      W_SATDATA:  return p_sats * (m7 ? 36 : 18);
      W_CELLSKIP: return p_cells * (m7 ? 55 : 42);
      W_CNR:      return p_cells != 0 ? (m7 ? 10 : 6) : 0;
      W_TAIL:     return p_cells * (m7 ? 15 : 0);
      default:    return 0;
    endcase
  endfunction

  task automatic advance_group();
    int unsigned ph;
    int unsigned n;
    ph = p_phase;
    n = 0;
    while (ph < W_DONE) begin
      ph++;
      n = group_bits(ph);
      if (n != 0) break;
    end
    p_phase = ph;
    p_togo = n;
  endtask

  task automatic walk_bit(int unsigned bt);
    int unsigned ph;
    int unsigned raw;
    ph = p_phase;
    if (ph < W_TYPE || ph >= W_DONE || p_togo == 0) return;
    p_shift = (p_shift << 1) | bt;
    if (ph == W_SATMASK) p_sats += bt;
    else if (ph == W_SIGMASK) p_sigs += bt;
    else if (ph == W_CELLMASK) p_cells += bt;
    p_togo--;
    if (p_togo != 0) return;
    if (ph == W_TYPE) begin
      p_type = p_shift & 12'hFFF;
      p_shift = 0;
      if (p_type < 1071 || p_type > 1127 || ((p_type % 10) != 4 && (p_type % 10) != 7)) begin
        p_phase = W_STOP;
        return;
      end
    end else if (ph == W_STATION) begin
      p_station = p_shift & 12'hFFF;
    end else if (ph == W_CNR) begin
      raw = p_shift & (walker_m7() ? 32'h3FF : 32'h3F);
      p_sum += walker_m7() ? (raw * 5) / 8 : raw * 10;
      p_read++;
      p_shift = 0;
      if (p_read < p_cells) begin
        p_togo = group_bits(W_CNR);
        return;
      end
    end
    p_shift = 0;
    advance_group();
  endtask

  function automatic int unsigned crc24q(int unsigned c, logic [7:0] b);
    c = c ^ (int'(b) << 16);
    for (int i = 0; i < 8; i++) begin
      c = c << 1;
      if (c & 32'h1000000) c = c ^ 32'h1864CFB;
    end
    return c & 32'hFFFFFF;
  endfunction

  task automatic clear_model();
    p_idx = 0; p_len = 0; p_crc = 0; p_rcrc = 0; p_phase = W_IDLE; p_shift = 0;
    p_togo = 0; p_type = 0; p_station = 0; p_sats = 0; p_sigs = 0; p_cells = 0;
    p_read = 0; p_sum = 0; p_err = 0;
  endtask

  // Fold one accepted byte into the model; queue a summary on the last byte
  task automatic predict_byte(logic [7:0] b, logic last);
    summary_t s;
    if (p_idx == 0) begin
      p_err = (b != msm_cnr_pkg::Preamble);
      p_phase = W_TYPE;
      p_togo = 12;
      p_shift = 0;
    end else if (p_idx == 1) begin
      p_len = int'(b & 8'h03) << 8;
    end else if (p_idx == 2) begin
      p_len = p_len | b;
    end
    if (p_idx < 3 + p_len) begin
      p_crc = crc24q(p_crc, b);
      if (p_idx >= 3) for (int i = 7; i >= 0; i--) walk_bit(b[i]);
    end else if (p_idx < p_len + 6) begin
      p_rcrc = ((p_rcrc << 8) | b) & 32'hFFFFFF;
    end
    p_idx = (p_idx < 2047) ? p_idx + 1 : 2047;
    if (!last) return;
    s = '0;
    if (p_err != 0 || p_idx != p_len + 6)
      s.status = msm_cnr_pkg::ST_BAD_FRAME;
    else if (p_crc != p_rcrc)
      s.status = msm_cnr_pkg::ST_BAD_CRC;
    else if (p_phase <= W_TYPE || p_type < 1071 || p_type > 1127)
      s.status = msm_cnr_pkg::ST_BAD_TYPE;
    else if ((p_type % 10) != 4 && (p_type % 10) != 7)
      s.status = msm_cnr_pkg::ST_BAD_MSM;
    else if (p_phase != W_DONE)
      s.status = msm_cnr_pkg::ST_TRUNC;
    else
      s.status = msm_cnr_pkg::ST_OK;
    if (s.status == msm_cnr_pkg::ST_OK) begin
      s.msg_type   = p_type;
      s.station_id = p_station;
      s.sat_count  = p_sats;
      s.sig_count  = p_sigs;
      s.mean_cnr   = p_cells != 0 ? (p_sum / p_cells) : 16'hFFFF;
    end
    summary_q.push_back(s);
    clear_model();
  endtask

  // ------------------------------------------------------------------ stimulus
  // Send one byte transfer, after an optional idle gap
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = no_idle ? 0 : gap_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic idle_sender();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic put_bits(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) body_bits.push_back(v[i]);
  endtask

  // Build an MSM body; cut drops that many bytes off the end
  task automatic build_msm(output byte_q_t body, input int unsigned typ,
                           input logic [63:0] sat_mask, input logic [31:0] sig_mask,
                           input int unsigned cell_pct, input int cnr_mode, input int cut);
    int unsigned nsat, nsig, ncell, cw;
    bit m7;
    logic [7:0] v;
    body_bits.delete();
    body = {};
    m7 = (typ % 10) == 7;
    nsat = $countones(sat_mask);
    nsig = $countones(sig_mask);
    put_bits(typ, 12);
    put_bits($urandom(), 12);
    put_bits({$urandom(), $urandom()}, 49);
    put_bits(sat_mask, 64);
    put_bits(sig_mask, 32);
    ncell = 0;
    for (int i = 0; i < nsat * nsig; i++) begin
      if ($urandom_range(1, 100) <= cell_pct) begin
        body_bits.push_back(1'b1);
        ncell++;
      end else begin
        body_bits.push_back(1'b0);
      end
    end
    for (int i = 0; i < nsat; i++) put_bits({$urandom(), $urandom()}, m7 ? 36 : 18);
    for (int i = 0; i < ncell; i++) put_bits({$urandom(), $urandom()}, m7 ? 55 : 42);
    cw = m7 ? 10 : 6;
    for (int i = 0; i < ncell; i++) begin
      case (cnr_mode)
        CNR_MIN: put_bits(0, cw);
        CNR_MAX: put_bits('1, cw);
        default: put_bits($urandom(), cw);
      endcase
    end
    if (m7) for (int i = 0; i < ncell; i++) put_bits($urandom(), 15);
    // Pad with random bits to whole bytes
    while (body_bits.size() % 8 != 0) body_bits.push_back($urandom_range(0, 1));
    for (int i = 0; i < body_bits.size(); i += 8) begin
      for (int k = 0; k < 8; k++) v[7 - k] = body_bits[i + k];
      body.push_back(v);
    end
    for (int i = 0; i < cut && body.size() > 0; i++) void'(body.pop_back());
  endtask

  // Wrap a body in preamble, length and CRC, then stream it
  task automatic send_frame(byte_q_t body, int fault);
    byte_q_t fr;
    int unsigned c;
    logic [9:0] len;
    logic [7:0] b;
    len = body.size();
    b = $urandom();
    if (b == msm_cnr_pkg::Preamble) b = ~b;
    fr.push_back(fault == F_PREAMBLE ? b : msm_cnr_pkg::Preamble);
    b = $urandom();
    fr.push_back({b[7:2], len[9:8]});
    fr.push_back(len[7:0]);
    foreach (body[i]) fr.push_back(body[i]);
    c = 0;
    foreach (fr[i]) c = crc24q(c, fr[i]);
    if (fault == F_CRC) c = c ^ (32'h1 << $urandom_range(0, 23));
    fr.push_back(c[23:16]);
    fr.push_back(c[15:8]);
    fr.push_back(c[7:0]);
    if (fault == F_LEN_SHORT) void'(fr.pop_back());
    if (fault == F_LEN_LONG) repeat ($urandom_range(1, 3)) fr.push_back($urandom());
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  task automatic msm_frame(int unsigned typ, logic [63:0] sm, logic [31:0] gm,
                           int unsigned pct, int cnr_mode, int cut, int fault);
    byte_q_t body;
    build_msm(body, typ, sm, gm, pct, cnr_mode, cut);
    send_frame(body, fault);
  endtask

  function automatic logic [63:0] sparse_mask(int unsigned nbits, int unsigned maxset);
    logic [63:0] m;
    m = '0;
    repeat ($urandom_range(0, maxset)) m[$urandom_range(0, nbits - 1)] = 1'b1;
    return m;
  endfunction

  function automatic int unsigned pick_msm_type();
    int unsigned t;
    t = 1070 + 10 * $urandom_range(0, 5) + ($urandom_range(0, 1) ? 4 : 7);
    return t;
  endfunction

  // ------------------------------------------------------------------- tests
  task automatic test_valid_messages();
    msm_frame(1074, 64'h0000_0000_0000_0013, 32'h0000_0006, 60, CNR_RAND, 0, F_NONE);
    msm_frame(1077, 64'h8000_0000_0000_0001, 32'h8000_0001, 100, CNR_RAND, 0, F_NONE);
    msm_frame(1127, 64'h0000_0F00_0000_0000, 32'h0000_0300, 70, CNR_MAX, 0, F_NONE);
    msm_frame(1124, 64'h0000_0000_0000_0007, 32'h0000_0001, 100, CNR_MAX, 0, F_NONE);
    msm_frame(1084, 64'h0000_0000_0000_0030, 32'h0000_0011, 100, CNR_MIN, 0, F_NONE);
  endtask

  // Every satellite, or every signal, present
  task automatic test_full_masks();
    msm_frame(1117, '1, 32'h0000_0010, 100, CNR_RAND, 0, F_NONE);
    msm_frame(1104, 64'h0000_0000_0200_0000, '1, 100, CNR_RAND, 0, F_NONE);
  endtask

  // No cells: empty masks, or masks set with an empty cell mask
  task automatic test_no_cells();
    msm_frame(1074, '0, '0, 0, CNR_RAND, 0, F_NONE);
    msm_frame(1097, 64'h0000_00F0_0000_0000, 32'h0000_0005, 0, CNR_RAND, 0, F_NONE);
    msm_frame(1114, 64'h0000_0000_0000_0001, '0, 0, CNR_RAND, 0, F_NONE);
  endtask

  task automatic test_bad_types();
    msm_frame(1070, 64'h3, 32'h1, 100, CNR_RAND, 0, F_NONE);
    msm_frame(1128, 64'h3, 32'h1, 100, CNR_RAND, 0, F_NONE);
    msm_frame(4095, 64'h3, 32'h1, 100, CNR_RAND, 0, F_NONE);
    msm_frame(1071, 64'h3, 32'h1, 100, CNR_RAND, 0, F_NONE);
    msm_frame(1125, 64'h3, 32'h1, 100, CNR_RAND, 0, F_NONE);
  endtask

  // Framing faults; a bad CRC also outranks a type that is no MSM4/MSM7
  task automatic test_frame_faults();
    byte_q_t body;
    msm_frame(1074, 64'h5, 32'h3, 80, CNR_RAND, 0, F_PREAMBLE);
    msm_frame(1077, 64'h5, 32'h3, 80, CNR_RAND, 0, F_LEN_SHORT);
    msm_frame(1077, 64'h5, 32'h3, 80, CNR_RAND, 0, F_LEN_LONG);
    msm_frame(1074, 64'h5, 32'h3, 80, CNR_RAND, 0, F_CRC);
    msm_frame(1071, 64'h5, 32'h3, 80, CNR_RAND, 0, F_CRC);
    // Payloads too short to hold the type
    body = {};
    send_frame(body, F_NONE);
    body = {8'hFF};
    send_frame(body, F_NONE);
    // Body cut short behind a consistent length and CRC
    msm_frame(1077, 64'hF, 32'h3, 100, CNR_RAND, 2, F_NONE);
    msm_frame(1094, 64'h1, 32'h1, 100, CNR_RAND, 1, F_NONE);
  endtask

  // A frame past 2047 bytes saturates the byte count
  task automatic test_overlong_frame();
    send_byte(msm_cnr_pkg::Preamble, 1'b0);
    for (int i = 1; i < 2100; i++) send_byte($urandom(), i == 2099);
  endtask

  task automatic test_random_frames();
    int unsigned frames;
    int unsigned r;
    int unsigned n;
    byte_q_t body;
    frames = 0;
    bytes_sent = 0;
    while (bytes_sent < 550 || frames < 40) begin
      no_idle = $urandom_range(0, 7) == 0;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        msm_frame(pick_msm_type(), sparse_mask(64, 4), sparse_mask(32, 3),
                  $urandom_range(0, 100), CNR_RAND, 0, F_NONE);
      end else if (r < 80) begin
        msm_frame(pick_msm_type(), sparse_mask(64, 3), sparse_mask(32, 2),
                  $urandom_range(0, 100), CNR_RAND, $urandom_range(1, 4), F_NONE);
      end else if (r < 90) begin
        msm_frame($urandom_range(1, 9) < 5 ? $urandom_range(0, 4095) : pick_msm_type(),
                  sparse_mask(64, 3), sparse_mask(32, 2), 50, CNR_RAND, 0,
                  $urandom_range(F_NONE, F_CRC));
      end else begin
        // Noise: random bytes with a random length
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) send_byte($urandom(), i == n - 1);
      end
      frames++;
    end
    no_idle = 1'b0;
  endtask

  // Hold the receiver off long enough that a second result backs up the input
  task automatic test_output_backpressure();
    hold_req = 3000;
    repeat (3) msm_frame(1074, 64'h1, 32'h1, 100, CNR_RAND, 0, F_NONE);
  endtask

  // ----------------------------------------------------------------- receiver
  always @(posedge clk) begin
    static int unsigned hold_left = 0;
    summary_t got;
    summary_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      // Check each result transfer against the oldest prediction
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (summary_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = summary_q.pop_front();
          if (got.status !== want.status || got.msg_type !== want.msg_type ||
              got.station_id !== want.station_id || got.sat_count !== want.sat_count ||
              got.sig_count !== want.sig_count || got.mean_cnr !== want.mean_cnr) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: expected st=%0d type=%0d stn=%0d sat=%0d sig=%0d cnr=%0d",
                       results_seen, want.status, want.msg_type, want.station_id,
                       want.sat_count, want.sig_count, want.mean_cnr);
              $display("result %0d: got      st=%0d type=%0d stn=%0d sat=%0d sig=%0d cnr=%0d",
                       results_seen, got.status, got.msg_type, got.station_id,
                       got.sat_count, got.sig_count, got.mean_cnr);
            end
          end
        end
      end
      // Pick next ready: long hold when asked, else always ready under no_idle, else random stalls
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (no_idle) begin
        m_tready <= 1'b1;
      end else begin
        hold_left = gap_len();
        m_tready <= hold_left == 0;
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    mismatches = 0;
    cycles = 0;
    results_seen = 0;
    bytes_sent = 0;
    hold_req = 0;
    no_idle = 1'b0;
    clear_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_valid_messages();
    test_full_masks();
    test_no_cells();
    test_bad_types();
    test_frame_faults();
    test_overlong_frame();
    test_random_frames();
    test_output_backpressure();
    idle_sender();

    // Drain the remaining results
    while (summary_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && summary_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
